>>> rtl/core/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types and constants of the binomial profit probability block.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int unsigned PROB_W     = 17;
  localparam int unsigned PAYOUT_W   = 16;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned Q16_SHIFT  = 16;

  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_PROBABILITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYOUT_MULTIPLE = 1'b1;

  localparam logic [PROB_W-1:0]   WIN_PROB_RESET = 17'd32768;
  localparam logic [PAYOUT_W-1:0] PAYOUT_RESET   = 16'd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_ROW_WAIT,
    ST_TAIL,
    ST_TAIL_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_acc;
    logic init;
    logic upd_vld;
    logic upd_first;
    logic upd_last;
    logic sum_vld;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/core/binomial_profit_probability.sv
// ----------------------------------------------------------------------------
// binomial_profit_probability
// Works on one request at a time: a zero stake goes straight to the output,
// otherwise every row of the recurrence and then the tail sum are run first.
// The next request is taken only once the result is loaded into the output.
// Reset restores configuration defaults and clears control, accumulator and
// output valid; the table is always written before it is read.
// ----------------------------------------------------------------------------
module binomial_profit_probability #(
  parameter int unsigned MAX_BETS  = 255,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_bet_count,
  input  logic [15:0]                     in_stake,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bpp_pkg::PROB_W-1:0]      out_profit_probability
);

  localparam int unsigned IDX_W = (MAX_BETS < 2) ? 1 : $clog2(MAX_BETS + 1);

  bpp_pkg::cmd_t    cmd;
  bpp_pkg::sts_t    sts;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] n;

  bpp_ctrl #(
    .MAX_BETS (MAX_BETS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_bet_count (in_bet_count),
    .in_stake     (in_stake),
    .cmd          (cmd),
    .idx          (idx),
    .n            (n),
    .sts          (sts)
  );

  bpp_dp #(
    .MAX_BETS  (MAX_BETS),
    .FRAC_BITS (FRAC_BITS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .cmd                    (cmd),
    .idx                    (idx),
    .n                      (n),
    .sts                    (sts),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_profit_probability (out_profit_probability)
  );

endmodule

>>> rtl/core/bpp_ctrl.sv
// ----------------------------------------------------------------------------
// bpp_ctrl
// Sequencer that walks the rows of the binomial recurrence and the tail sum.
// ----------------------------------------------------------------------------
module bpp_ctrl #(
  parameter int unsigned MAX_BETS = 255,
  parameter int unsigned IDX_W    = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_bet_count,
  input  logic [15:0]      in_stake,
  output bpp_pkg::cmd_t    cmd,
  output logic [IDX_W-1:0] idx,
  output logic [IDX_W-1:0] n,
  input  bpp_pkg::sts_t    sts
);

  localparam int unsigned CMP_W = (IDX_W > 8) ? IDX_W : 8;

  bpp_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [CMP_W-1:0] bc_ext;
  logic [IDX_W-1:0] n_sat;
  logic             stake_zero;

  assign bc_ext     = CMP_W'(in_bet_count);
  assign n_sat      = (bc_ext > CMP_W'(MAX_BETS)) ? IDX_W'(MAX_BETS) : IDX_W'(bc_ext);
  assign stake_zero = (in_stake == 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpp_pkg::ST_IDLE;
      n_r     <= '0;
      j_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stake_zero ? bpp_pkg::ST_DONE : bpp_pkg::ST_INIT;
        end
      end
      bpp_pkg::ST_INIT: begin
        state_nxt = (n_r == '0) ? bpp_pkg::ST_TAIL : bpp_pkg::ST_ROW;
      end
      bpp_pkg::ST_ROW: begin
        if (i_r == '0) begin
          state_nxt = bpp_pkg::ST_ROW_WAIT;
        end
      end
      bpp_pkg::ST_ROW_WAIT: begin
        if (sts.pipe_empty) begin
          state_nxt = (j_r == n_r) ? bpp_pkg::ST_TAIL : bpp_pkg::ST_ROW;
        end
      end
      bpp_pkg::ST_TAIL: begin
        if (i_r == n_r) begin
          state_nxt = bpp_pkg::ST_TAIL_WAIT;
        end
      end
      bpp_pkg::ST_TAIL_WAIT: begin
        if (sts.pipe_empty) begin
          state_nxt = bpp_pkg::ST_DONE;
        end
      end
      bpp_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = bpp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    n_nxt = n_r;
    j_nxt = j_r;
    i_nxt = i_r;
    unique case (state_r)
      bpp_pkg::ST_IDLE: begin
        if (in_valid) begin
          n_nxt = n_sat;
        end
      end
      bpp_pkg::ST_INIT: begin
        j_nxt = '0;
        i_nxt = (n_r == '0) ? '0 : IDX_W'(1);
      end
      bpp_pkg::ST_ROW: begin
        if (i_r == '0) begin
          j_nxt = j_r + IDX_W'(1);
        end else begin
          i_nxt = i_r - IDX_W'(1);
        end
      end
      bpp_pkg::ST_ROW_WAIT: begin
        if (sts.pipe_empty) begin
          i_nxt = (j_r == n_r) ? '0 : j_r + IDX_W'(1);
        end
      end
      bpp_pkg::ST_TAIL: begin
        if (i_r != n_r) begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      bpp_pkg::ST_TAIL_WAIT, bpp_pkg::ST_DONE: begin
        i_nxt = i_r;
      end
      default: i_nxt = i_r;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bpp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.clr_acc = in_valid;
      end
      bpp_pkg::ST_INIT: begin
        cmd.init = 1'b1;
      end
      bpp_pkg::ST_ROW: begin
        cmd.upd_vld   = 1'b1;
        cmd.upd_first = (i_r == j_r + IDX_W'(1));
        cmd.upd_last  = (i_r == '0);
      end
      bpp_pkg::ST_TAIL: begin
        cmd.sum_vld = 1'b1;
      end
      bpp_pkg::ST_DONE: begin
        cmd.load_out = !sts.out_busy;
      end
      bpp_pkg::ST_ROW_WAIT, bpp_pkg::ST_TAIL_WAIT: begin
        cmd = '0;
      end
      default: cmd = '0;
    endcase
  end

  assign idx = i_r;
  assign n   = n_r;

endmodule

>>> rtl/core/bpp_dp.sv
// ----------------------------------------------------------------------------
// bpp_dp
// Probability table, update pipeline, tail accumulator and output register.
// ----------------------------------------------------------------------------
module bpp_dp #(
  parameter int unsigned MAX_BETS  = 255,
  parameter int unsigned FRAC_BITS = 24,
  parameter int unsigned IDX_W     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bpp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bpp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  bpp_pkg::cmd_t                        cmd,
  input  logic [IDX_W-1:0]                     idx,
  input  logic [IDX_W-1:0]                     n,
  output bpp_pkg::sts_t                        sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bpp_pkg::PROB_W-1:0]           out_profit_probability
);

  localparam int unsigned VAL_W  = FRAC_BITS + 1;
  localparam int unsigned PROD_W = VAL_W + bpp_pkg::PROB_W;
  localparam int unsigned SUM_W  = VAL_W + 2;
  localparam int unsigned ACC_W  = FRAC_BITS + 2;
  localparam int unsigned WIN_W  = IDX_W + bpp_pkg::PAYOUT_W;

  localparam logic [VAL_W-1:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [bpp_pkg::PROB_W-1:0]   win_prob_r;
  logic [bpp_pkg::PAYOUT_W-1:0] payout_r;
  logic [bpp_pkg::PROB_W-1:0]   p_r, q_r, p_sat;

  logic [VAL_W-1:0] mem [0:MAX_BETS];
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data_r;

  logic             s1_vld_r, s1_first_r, s1_last_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [VAL_W-1:0] carry_r;
  logic [VAL_W-1:0] op_a, op_b;

  logic              s2_vld_r;
  logic [IDX_W-1:0]  s2_idx_r;
  logic [PROD_W-1:0] pa_r, pb_r;
  logic [SUM_W-1:0]  upd_sum;
  logic [VAL_W-1:0]  upd_sat;

  logic             t1_vld_r, t1_win_r;
  logic             win_hit;
  logic [ACC_W-1:0] acc_r, acc_nxt, acc_sum;

  logic                       out_valid_r;
  logic [bpp_pkg::PROB_W-1:0] out_prob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_prob_r <= bpp_pkg::WIN_PROB_RESET;
      payout_r   <= bpp_pkg::PAYOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpp_pkg::CFG_WIN_PROBABILITY: win_prob_r <= cfg_wdata;
        bpp_pkg::CFG_PAYOUT_MULTIPLE: payout_r   <= cfg_wdata[bpp_pkg::PAYOUT_W-1:0];
        default: payout_r <= payout_r;
      endcase
    end
  end

  assign p_sat = (win_prob_r > bpp_pkg::PROB_ONE) ? bpp_pkg::PROB_ONE : win_prob_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      p_r <= p_sat;
      q_r <= bpp_pkg::PROB_ONE - p_sat;
    end
  end

  assign rd_addr = (cmd.upd_vld && !cmd.upd_last) ? idx - IDX_W'(1) : idx;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      mem[0] <= FIX_ONE;
    end else if (s2_vld_r) begin
      mem[s2_idx_r] <= upd_sat;
    end
  end

  assign op_a = s1_first_r ? '0 : carry_r;
  assign op_b = s1_last_r  ? '0 : rd_data_r;

  assign upd_sum = SUM_W'(pa_r[PROD_W-1:bpp_pkg::Q16_SHIFT])
                 + SUM_W'(pb_r[PROD_W-1:bpp_pkg::Q16_SHIFT]);
  assign upd_sat = (upd_sum > SUM_W'(FIX_ONE)) ? FIX_ONE : upd_sum[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      t1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.upd_vld;
      s2_vld_r <= s1_vld_r;
      t1_vld_r <= cmd.sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.upd_first;
    s1_last_r  <= cmd.upd_last;
    s1_idx_r   <= idx;
    s2_idx_r   <= s1_idx_r;
    pa_r       <= PROD_W'(op_a) * PROD_W'(q_r);
    pb_r       <= PROD_W'(op_b) * PROD_W'(p_r);
    t1_win_r   <= win_hit;
    if (s1_vld_r) begin
      carry_r <= op_b;
    end
  end

  assign win_hit = (WIN_W'(idx) * WIN_W'(payout_r)) > WIN_W'({n, 8'h00});

  assign acc_sum = acc_r + ACC_W'(rd_data_r);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.clr_acc) begin
      acc_nxt = '0;
    end else if (t1_vld_r && t1_win_r) begin
      acc_nxt = (acc_sum > ACC_W'(FIX_ONE)) ? ACC_W'(FIX_ONE) : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_prob_r <= acc_r[FRAC_BITS:FRAC_BITS-16];
    end
  end

  assign sts.pipe_empty = !s1_vld_r && !s2_vld_r && !t1_vld_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid              = out_valid_r;
  assign out_profit_probability = out_prob_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binomial profit probability testbench
// Sends bet requests over the valid/ready input, reprograms the win
// probability and payout between phases, and checks every result word
// against its typed value or a fixed-point model of the binomial win-count recurrence.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_BETS         = 255;
  localparam int unsigned FRAC_BITS        = 24;
  localparam int          NUM_DIRECTED     = 20;
  localparam int          NUM_PHASES       = 5;
  localparam int          ITEMS_PER_PHASE  = 16;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          LONG_HOLD_AT     = NUM_DIRECTED + 2;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES     = 50;
  // Every request at the largest bet count with both sides at their longest
  // gaps still finishes well inside this bound.
  localparam int          CYCLE_LIMIT      = 5_000_000;

  typedef struct packed {
    logic [bpp_pkg::PROB_W-1:0]     win_prob;
    logic [bpp_pkg::CFG_DATA_W-1:0] payout_raw;
    logic [7:0]                     bets;
    logic [15:0]                    stake;
    bit                             typed;
    logic [bpp_pkg::PROB_W-1:0]     result;
  } request_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bpp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bpp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [7:0]                     in_bet_count;
  logic [15:0]                    in_stake;
  logic                           out_valid;
  logic                           out_ready;
  logic [bpp_pkg::PROB_W-1:0]     out_profit_probability;

  logic [bpp_pkg::PROB_W-1:0]     win_prob_q16;
  logic [bpp_pkg::CFG_DATA_W-1:0] payout_raw;
  logic [bpp_pkg::PROB_W-1:0]     expected_probabilities[$];
  bit                             quiet;
  int                             fail_count;
  int                             results_seen;
  int                             cycle_count;

  // Rows with a typed result are checked against that value.
  request_row_t directed_rows [NUM_DIRECTED] = '{
    '{17'd32768,  17'd512,    8'd0,   16'd1,      1'b1, 17'd0},
    '{17'd32768,  17'd512,    8'd10,  16'd0,      1'b1, 17'd0},
    '{17'd32768,  17'd512,    8'd255, 16'd0,      1'b1, 17'd0},
    '{17'd32768,  17'd512,    8'd1,   16'd1,      1'b0, 17'd0},
    '{17'd32768,  17'd512,    8'd255, 16'd65535,  1'b0, 17'd0},
    '{17'd32768,  17'd512,    8'd37,  16'h5A5A,   1'b0, 17'd0},
    '{17'd65536,  17'd512,    8'd7,   16'd100,    1'b1, 17'd65536},
    '{17'd65536,  17'd512,    8'd255, 16'd1,      1'b1, 17'd65536},
    '{17'd131071, 17'd512,    8'd5,   16'd3,      1'b1, 17'd65536},
    '{17'd0,      17'd512,    8'd20,  16'd9,      1'b1, 17'd0},
    '{17'd0,      17'd512,    8'd1,   16'd65535,  1'b1, 17'd0},
    '{17'd32768,  17'd0,      8'd30,  16'd77,     1'b1, 17'd0},
    '{17'd32768,  17'd256,    8'd12,  16'd5,      1'b1, 17'd0},
    '{17'd32768,  17'd65535,  8'd3,   16'd1,      1'b0, 17'd0},
    '{17'd32768,  17'd65535,  8'd1,   16'd2,      1'b1, 17'd32768},
    '{17'd40000,  17'd257,    8'd200, 16'd300,    1'b0, 17'd0},
    '{17'd40000,  17'h10200,  8'd9,   16'd1234,   1'b0, 17'd0},
    '{17'd1,      17'd65535,  8'd255, 16'hFFFF,   1'b0, 17'd0},
    '{17'd65535,  17'd300,    8'd128, 16'h8001,   1'b0, 17'd0},
    '{17'd32768,  17'd512,    8'd2,   16'h00FF,   1'b0, 17'd0}
  };

  binomial_profit_probability #(
    .MAX_BETS (MAX_BETS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_bet_count          (in_bet_count),
    .in_stake              (in_stake),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_profit_probability(out_profit_probability)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [bpp_pkg::PROB_W-1:0] predict_profit_probability(
    input logic [7:0] bets, input logic [15:0] stake);
    bit [63:0] win_odds [0:MAX_BETS];
    bit [63:0] one_fix;
    bit [63:0] p;
    bit [63:0] q;
    bit [63:0] sum;
    bit [63:0] tail;
    int        n;
    one_fix = 64'd1 << FRAC_BITS;
    n = int'(bets);
    if (n > MAX_BETS) n = MAX_BETS;
    if (stake == 16'd0) return '0;
    p = (win_prob_q16 > bpp_pkg::PROB_ONE) ? 64'(bpp_pkg::PROB_ONE) : 64'(win_prob_q16);
    q = 64'(bpp_pkg::PROB_ONE) - p;
    for (int i = 0; i <= n; i++) win_odds[i] = '0;
    win_odds[0] = one_fix;
    for (int j = 0; j < n; j++) begin
      for (int i = j + 1; i > 0; i--) begin
        sum = ((win_odds[i] * q) >> bpp_pkg::Q16_SHIFT)
            + ((win_odds[i-1] * p) >> bpp_pkg::Q16_SHIFT);
        win_odds[i] = (sum > one_fix) ? one_fix : sum;
      end
      win_odds[0] = (win_odds[0] * q) >> bpp_pkg::Q16_SHIFT;
    end
    tail = '0;
    for (int i = 0; i <= n; i++) begin
      if (64'(i) * 64'(payout_raw[bpp_pkg::PAYOUT_W-1:0]) > (64'(n) << 8)) begin
        tail = tail + win_odds[i];
        if (tail > one_fix) tail = one_fix;
      end
    end
    tail = tail >> (FRAC_BITS - 16);
    if (tail > 64'(bpp_pkg::PROB_ONE)) tail = 64'(bpp_pkg::PROB_ONE);
    return tail[bpp_pkg::PROB_W-1:0];
  endfunction

  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic note_failure(input string what,
                              input logic [bpp_pkg::PROB_W-1:0] want,
                              input logic [bpp_pkg::PROB_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_probabilities.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [bpp_pkg::PROB_W-1:0] wp,
                                input logic [bpp_pkg::CFG_DATA_W-1:0] pm_raw);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bpp_pkg::CFG_WIN_PROBABILITY;
    cfg_wdata <= wp;
    @(posedge clk);
    cfg_index <= bpp_pkg::CFG_PAYOUT_MULTIPLE;
    cfg_wdata <= pm_raw;
    @(posedge clk);
    cfg_we       <= 1'b0;
    win_prob_q16 = wp;
    payout_raw   = pm_raw;
  endtask

  task automatic send_request(input logic [7:0] bets, input logic [15:0] stake,
                              input bit typed,
                              input logic [bpp_pkg::PROB_W-1:0] typed_val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_bet_count <= bets;
    in_stake     <= stake;
    do @(posedge clk); while (!in_ready);
    expected_probabilities.push_back(typed ? typed_val
                                           : predict_profit_probability(bets, stake));
  endtask

  initial begin
    int                             pick;
    logic [7:0]                     bets;
    logic [15:0]                    stake;
    logic [bpp_pkg::PROB_W-1:0]     wp;
    logic [bpp_pkg::CFG_DATA_W-1:0] pm;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= bpp_pkg::CFG_WIN_PROBABILITY;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_bet_count <= '0;
    in_stake     <= '0;
    win_prob_q16 = bpp_pkg::WIN_PROB_RESET;
    payout_raw   = {1'b0, bpp_pkg::PAYOUT_RESET};
    quiet        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].win_prob != win_prob_q16 ||
          directed_rows[r].payout_raw != payout_raw)
        apply_settings(directed_rows[r].win_prob, directed_rows[r].payout_raw);
      send_request(directed_rows[r].bets, directed_rows[r].stake,
                   directed_rows[r].typed, directed_rows[r].result);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) wp = '0;
      else if (pick == 1) wp = bpp_pkg::PROB_ONE;
      else if (pick == 2) wp = 17'($urandom_range(65537, 131071));
      else wp = 17'($urandom_range(1, 65535));
      pick = $urandom_range(0, 9);
      if (pick == 0) pm = 17'($urandom_range(0, 131071));
      else if (pick == 1) pm = 17'd256;
      else pm = 17'($urandom_range(128, 1024));
      apply_settings(wp, pm);
      quiet = (ph == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 1 && k == ITEMS_PER_PHASE / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 6) bets = 8'($urandom_range(128, 255));
        else if (pick < 16) bets = 8'($urandom_range(25, 127));
        else bets = 8'($urandom_range(0, 24));
        stake = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        send_request(bets, stake, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    int                         gap;
    logic [bpp_pkg::PROB_W-1:0] want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen == LONG_HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (expected_probabilities.size() == 0) begin
        note_failure("unexpected word", '0, out_profit_probability);
      end else begin
        want = expected_probabilities.pop_front();
        if (out_profit_probability !== want)
          note_failure("profit_probability mismatch", want, out_profit_probability);
      end
    end
  end

endmodule
